// ===== rtl/core/jed_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jed_pkg;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_HEX  = 3'd1,
      PH_LOW  = 3'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK           = 3'd0,
      ST_INCOMPLETE   = 3'd1,
      ST_BAD_CHAR     = 3'd2,
      ST_INCOMPLETE_U = 3'd3,
      ST_BAD_HEX      = 3'd4,
      ST_NO_LOW       = 3'd5,
      ST_BAD_LOW      = 3'd6,
      ST_NO_HIGH      = 3'd7
   } status_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
   localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

   typedef struct packed {
      phase_type   phase;
      logic [2:0]  byte_count;
      logic [15:0] high_value;
      logic [15:0] low_value;
      logic [2:0]  bad_hex_pos;
      logic        no_low_seen;
   } state_type;

   typedef struct packed {
      logic [20:0] code_point;
      status_type  status;
      logic [3:0]  consumed;
   } result_type;

   // bit 4 set: not a hex digit
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39)      v = {1'b0, c[3:0]};
      else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
         v = {1'b0, c[3:0] + 4'd9};
      else                               v = 5'h10;
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jed_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface jed_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       at_end;

   modport source (output valid, output data_byte, output at_end, input ready);
   modport sink   (input valid, input data_byte, input at_end, output ready);
endinterface

interface jed_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [2:0]  status;
   logic [3:0]  consumed;

   modport source (output valid, output code_point, output status, output consumed,
                   input ready);
   modport sink   (input valid, input code_point, input status, input consumed,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/jed_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jed_step (
   input  jed_pkg::state_type  cur,
   input  logic [7:0]          data_byte,
   input  logic                at_end,
   output jed_pkg::state_type  nxt,
   output logic                emit,
   output jed_pkg::result_type res
);

   logic [4:0]  hv;
   logic        bad;
   logic [2:0]  cnt;
   logic [2:0]  pos;
   logic [15:0] high_nxt;
   logic [15:0] low_nxt;
   logic        nolow;
   logic [20:0] joined;

   assign hv  = jed_pkg::hex_val(data_byte);
   assign bad = hv[4];
   assign cnt = cur.byte_count + 3'd1;
   assign high_nxt = bad ? cur.high_value : {cur.high_value[11:0], hv[3:0]};
   assign low_nxt  = bad ? cur.low_value  : {cur.low_value[11:0], hv[3:0]};
   assign joined = 21'h10000 + {1'b0, cur.high_value[9:0], low_nxt[9:0]};

   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      res  = '{code_point: '0, status: jed_pkg::ST_OK, consumed: '0};
      pos  = cur.bad_hex_pos;
      nolow = cur.no_low_seen;
      unique case (cur.phase)
         jed_pkg::PH_HEX: begin
            if (at_end) begin
               emit = 1'b1;
               res.status = jed_pkg::ST_INCOMPLETE_U;
               res.consumed = 4'd1;
            end else begin
               if (bad && cur.bad_hex_pos == 3'd0) pos = cnt;
               nxt.byte_count = cnt;
               nxt.bad_hex_pos = pos;
               nxt.high_value = high_nxt;
               if (cnt == 3'd4) begin
                  if (pos != 3'd0) begin
                     emit = 1'b1;
                     res.status = jed_pkg::ST_BAD_HEX;
                     res.consumed = 4'd1 + {1'b0, pos};
                  end else if (high_nxt[15:10] == jed_pkg::HIGH_SURR_TAG) begin
                     nxt.phase = jed_pkg::PH_LOW;
                     nxt.byte_count = '0;
                     nxt.bad_hex_pos = '0;
                     nxt.no_low_seen = 1'b0;
                     nxt.low_value = '0;
                  end else if (high_nxt[15:10] == jed_pkg::LOW_SURR_TAG) begin
                     emit = 1'b1;
                     res.status = jed_pkg::ST_NO_HIGH;
                     res.consumed = 4'd5;
                  end else begin
                     emit = 1'b1;
                     res.code_point = {5'd0, high_nxt};
                     res.consumed = 4'd5;
                  end
               end
            end
         end
         jed_pkg::PH_LOW: begin
            if (at_end) begin
               emit = 1'b1;
               res.status = jed_pkg::ST_NO_LOW;
               res.consumed = 4'd5;
            end else begin
               nxt.byte_count = cnt;
               if (cnt == 3'd1) begin
                  if (data_byte != jed_pkg::CH_BSLASH) nolow = 1'b1;
               end else if (cnt == 3'd2) begin
                  if (data_byte != jed_pkg::CH_U) nolow = 1'b1;
               end else begin
                  if (bad && cur.bad_hex_pos == 3'd0) pos = cnt - 3'd2;
                  nxt.low_value = low_nxt;
               end
               nxt.no_low_seen = nolow;
               nxt.bad_hex_pos = pos;
               if (cnt == 3'd6) begin
                  emit = 1'b1;
                  if (nolow) begin
                     res.status = jed_pkg::ST_NO_LOW;
                     res.consumed = 4'd5;
                  end else if (pos != 3'd0) begin
                     res.status = jed_pkg::ST_BAD_HEX;
                     res.consumed = 4'd7 + {1'b0, pos};
                  end else if (low_nxt[15:10] != jed_pkg::LOW_SURR_TAG) begin
                     res.status = jed_pkg::ST_BAD_LOW;
                     res.consumed = 4'd5;
                  end else begin
                     res.code_point = joined;
                     res.consumed = 4'd11;
                  end
               end
            end
         end
         default: begin
            // idle, and unused phase codes
            emit = 1'b1;
            if (at_end) begin
               res.status = jed_pkg::ST_INCOMPLETE;
            end else begin
               res.consumed = 4'd1;
               case (data_byte) inside
                  jed_pkg::CH_QUOTE, jed_pkg::CH_BSLASH, jed_pkg::CH_SLASH:
                     res.code_point = {13'd0, data_byte};
                  jed_pkg::CH_B: res.code_point = 21'h08;
                  jed_pkg::CH_F: res.code_point = 21'h0C;
                  jed_pkg::CH_N: res.code_point = 21'h0A;
                  jed_pkg::CH_R: res.code_point = 21'h0D;
                  jed_pkg::CH_T: res.code_point = 21'h09;
                  jed_pkg::CH_U: begin
                     emit = 1'b0;
                     nxt = '0;
                     nxt.phase = jed_pkg::PH_HEX;
                  end
                  default: res.status = jed_pkg::ST_BAD_CHAR;
               endcase
            end
         end
      endcase
      if (emit) nxt = '0;
   end

endmodule

`default_nettype wire

// ===== rtl/core/json_escape_decoder.sv =====
// A byte accepted on req_bus is held in the input register; when it advances, any
// result it completes is written to the result register that drives rsp_bus.
// Throughput: one byte per cycle; the only stall is a held result on rsp_bus.
// Reset (synchronous, active high) empties both stages and returns the decoder
// to waiting for an escape character.
`timescale 1ns / 1ps
`default_nettype none

module json_escape_decoder (
   input  wire        clock,
   input  wire        reset,
   jed_req_if.sink    req_bus,
   jed_rsp_if.source  rsp_bus
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_end_ff;
   jed_pkg::state_type state_ff, state_in;
   logic               out_valid_ff, out_valid_in;
   jed_pkg::result_type out_ff;
   jed_pkg::result_type step_res;
   logic               step_emit;
   logic               advance;

   assign advance = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;

   jed_step u_step (
      .cur       (state_ff),
      .data_byte (in_byte_ff),
      .at_end    (in_end_ff),
      .nxt       (state_in),
      .emit      (step_emit),
      .res       (step_res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_bus.ready) in_valid_in = req_bus.valid;
      out_valid_in = out_valid_ff;
      if (rsp_bus.ready) out_valid_in = 1'b0;
      if (advance && step_emit) out_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         in_byte_ff <= req_bus.data_byte;
         in_end_ff  <= req_bus.at_end;
      end
      if (advance && step_emit) out_ff <= step_res;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_ff.code_point;
   assign rsp_bus.status     = out_ff.status;
   assign rsp_bus.consumed   = out_ff.consumed;

endmodule

`default_nettype wire

// ===== rtl/core/jed_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jed_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [20:0] rsp_code_point,
   input wire [2:0]  rsp_status,
   input wire [3:0]  rsp_consumed
);

   // errors never carry a code point
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != jed_pkg::ST_OK |-> rsp_code_point == 21'd0)
      else $error("error transaction with nonzero code point");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == jed_pkg::ST_OK |->
         rsp_consumed == 4'd1 || rsp_consumed == 4'd5 || rsp_consumed == 4'd11)
      else $error("ok transaction with bad consumed count");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_status) && $stable(rsp_consumed))
      else $error("stalled result changed");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind json_escape_decoder jed_checker u_jed_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_code_point (rsp_bus.code_point),
   .rsp_status     (rsp_bus.status),
   .rsp_consumed   (rsp_bus.consumed)
);

`default_nettype wire
